// File: src/u8s_pkg.sv
// Shared types, constants and lead-byte classification for the UTF-8 byte sanitizer.
// Depends on nothing; the front, queue, back and top files import it.
`default_nettype none
package u8s_pkg;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam logic [2:0] LEN_NONE  = 3'd0;
    localparam logic [2:0] LEN_ONE   = 3'd1;
    localparam logic [1:0] CONT_MARK = 2'b10;

    // one completed group of results: up to four kept bytes, then maybe an end marker
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [2:0]      nbytes;
        logic            eos;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    function automatic logic [2:0] lead_length(input logic [7:0] b);
        logic [2:0] len;
        case (b) inside
            [8'h00:8'h7F]: len = 3'd1;
            [8'hC2:8'hDF]: len = 3'd2;
            [8'hE0:8'hEF]: len = 3'd3;
            [8'hF0:8'hF4]: len = 3'd4;
            default:       len = LEN_NONE;
        endcase
        return len;
    endfunction

endpackage
`default_nettype wire

// File: src/u8s_front.sv
// Front end: classifies each accepted byte, holds a pending multi-byte sequence
// and issues a job when a sequence completes or the string ends. Uses u8s_pkg.
`default_nettype none
module u8s_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          accept,
    input  wire logic [7:0]    in_byte,
    input  wire logic          is_last,
    output logic               job_push,
    output u8s_pkg::job_t      job
);
    import u8s_pkg::*;

    logic [2:0]      seq_len_reg, seq_len_next;
    logic [1:0]      held_cnt_reg, held_cnt_next;
    logic [2:0][7:0] held_reg, held_next;
    logic [2:0]      need;
    logic            cont;
    logic            as_lead;

    always_comb
    begin
        seq_len_next  = seq_len_reg;
        held_cnt_next = held_cnt_reg;
        held_next     = held_reg;
        job           = '0;
        job.eos       = is_last;
        as_lead       = 1'b1;
        need          = lead_length(in_byte);
        cont          = (in_byte[7:6] == CONT_MARK);

        if (seq_len_reg != LEN_NONE)
        begin
            if (cont)
            begin
                as_lead = 1'b0;
                if (({1'b0, held_cnt_reg} + 3'd1) >= seq_len_reg)
                begin
                    // sequence complete: release held bytes plus this one
                    for (int i = 0; i < 3; i++)
                    begin
                        job.bytes[i] = held_reg[i];
                    end
                    job.bytes[held_cnt_reg] = in_byte;
                    job.nbytes    = {1'b0, held_cnt_reg} + 3'd1;
                    seq_len_next  = LEN_NONE;
                    held_cnt_next = 2'd0;
                end
                else if (held_cnt_reg != 2'd3)
                begin
                    held_next[held_cnt_reg] = in_byte;
                    held_cnt_next           = held_cnt_reg + 2'd1;
                end
            end
            else
            begin
                // broken sequence: drop held bytes, reclassify this byte
                seq_len_next  = LEN_NONE;
                held_cnt_next = 2'd0;
            end
        end

        if (as_lead)
        begin
            if (need == LEN_ONE)
            begin
                job.bytes[0] = in_byte;
                job.nbytes   = 3'd1;
            end
            else if (need != LEN_NONE)
            begin
                held_next[0]  = in_byte;
                held_cnt_next = 2'd1;
                seq_len_next  = need;
            end
        end

        if (is_last)
        begin
            seq_len_next  = LEN_NONE;
            held_cnt_next = 2'd0;
        end
    end

    assign job_push = accept && ((job.nbytes != 3'd0) || is_last);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_len_reg  <= LEN_NONE;
            held_cnt_reg <= 2'd0;
        end
        else if (accept)
        begin
            seq_len_reg  <= seq_len_next;
            held_cnt_reg <= held_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            held_reg <= held_next;
        end
    end

endmodule
`default_nettype wire

// File: src/u8s_queue.sv
// Short job queue between front and back end, so each side can stall alone.
// Uses u8s_pkg for the job type and depth.
`default_nettype none
module u8s_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire u8s_pkg::job_t push_job,
    input  wire logic          pop,
    output u8s_pkg::job_t      head_job,
    output u8s_pkg::q_status_t status
);
    import u8s_pkg::*;

    job_t              mem [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;
    logic              do_push, do_pop;

    assign status.full  = (cnt_reg == QCNT_W'(QDEPTH));
    assign status.empty = (cnt_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head_job     = mem[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + QCNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

endmodule
`default_nettype wire

// File: src/u8s_back.sv
// Back end: takes jobs from the queue and emits their results one per cycle
// through an output register while it is popped or empty. Uses u8s_pkg.
`default_nettype none
module u8s_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire u8s_pkg::job_t head_job,
    input  wire logic          q_empty,
    output logic               q_pop,
    input  wire logic          pop,
    output logic               empty,
    output logic [7:0]         out_byte,
    output logic               has_byte,
    output logic               end_of_string
);
    import u8s_pkg::*;

    job_t       job_reg;
    logic       job_valid_reg;
    logic [2:0] pos_reg;
    logic       out_valid_reg;
    logic [7:0] out_byte_reg;
    logic       has_reg;
    logic       eos_reg;

    logic       load;
    logic       emit;
    logic       last_elem;
    logic       take;
    logic [2:0] total;
    logic       pos_is_byte;

    assign total       = job_reg.nbytes + {2'b00, job_reg.eos};
    assign pos_is_byte = (pos_reg < job_reg.nbytes);
    assign load        = !out_valid_reg || pop;
    assign emit        = load && job_valid_reg;
    assign last_elem   = ((pos_reg + 3'd1) == total);
    assign take        = !job_valid_reg || (emit && last_elem);
    assign q_pop       = take && !q_empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_valid_reg <= 1'b0;
            pos_reg       <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                out_valid_reg <= job_valid_reg;
            end
            if (take)
            begin
                job_valid_reg <= !q_empty;
                pos_reg       <= 3'd0;
            end
            else if (emit)
            begin
                pos_reg <= pos_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            job_reg <= head_job;
        end
        if (emit)
        begin
            out_byte_reg <= pos_is_byte ? job_reg.bytes[pos_reg[1:0]] : 8'h00;
            has_reg      <= pos_is_byte;
            eos_reg      <= !pos_is_byte;
        end
    end

    assign empty         = !out_valid_reg;
    assign out_byte      = out_byte_reg;
    assign has_byte      = has_reg;
    assign end_of_string = eos_reg;

endmodule
`default_nettype wire

// File: src/utf8_byte_sanitizer_top.sv
// UTF-8 byte sanitizer: accepts one byte per cycle while not full, passes only whole sequences.
// Throughput: results leave at one per cycle through the output reg while popped or empty.
// A result passes the job queue, the back end's job register and its output register to the ports.
// Bytes of a multi-byte sequence wait in the front end until its last continuation byte.
// Reset (rst_n low, asynchronous) drops any pending sequence, queued jobs and results.
// Depends on u8s_pkg, u8s_front, u8s_queue, u8s_back.
`default_nettype none
module utf8_byte_sanitizer_top (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    output logic            full,
    input  wire logic [7:0] in_byte,
    input  wire logic       is_last,
    output logic            empty,
    input  wire logic       pop,
    output logic [7:0]      out_byte,
    output logic            has_byte,
    output logic            end_of_string
);
    import u8s_pkg::*;

    logic      accept;
    logic      job_push;
    job_t      new_job;
    job_t      head_job;
    q_status_t q_status;
    logic      q_pop;

    // Hold off new requests whenever the job queue cannot take one more job;
    // a byte that yields no job is held off too, which keeps the front simple.
    assign full   = q_status.full;
    assign accept = push && !full;

    // Front end: classify the byte, advance the pending sequence, build a job
    // of released bytes plus the end marker flag.
    u8s_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .in_byte  (in_byte),
        .is_last  (is_last),
        .job_push (job_push),
        .job      (new_job)
    );

    // Decouple front and back: a burst of up to five results from one byte
    // drains here while the front keeps taking requests.
    u8s_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (job_push),
        .push_job (new_job),
        .pop      (q_pop),
        .head_job (head_job),
        .status   (q_status)
    );

    // Back end: walk each job's bytes, then its end marker, one per cycle while popped.
    u8s_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head_job      (head_job),
        .q_empty       (q_status.empty),
        .q_pop         (q_pop),
        .pop           (pop),
        .empty         (empty),
        .out_byte      (out_byte),
        .has_byte      (has_byte),
        .end_of_string (end_of_string)
    );

endmodule
`default_nettype wire

// File: src/u8s_checker.sv
// Port-level checks for the UTF-8 byte sanitizer, bound to the top level.
// Depends on utf8_byte_sanitizer_top's port list only.
`default_nettype none
module u8s_port_props (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       push,
    input wire logic       full,
    input wire logic [7:0] in_byte,
    input wire logic       is_last,
    input wire logic       empty,
    input wire logic       pop,
    input wire logic [7:0] out_byte,
    input wire logic       has_byte,
    input wire logic       end_of_string
);

    // a shown result is either a kept byte or the end marker, never both
    a_kind_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (has_byte != end_of_string))
        else $error("result is neither exactly a byte nor an end marker");

    // the end marker carries a zero byte
    a_marker_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && end_of_string) |-> (out_byte == 8'h00))
        else $error("end marker with nonzero byte");

    // just out of reset, an empty block that accepts no request stays empty
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        ($past(!rst_n) && empty && !(push && !full)) |=> empty)
        else $error("result appeared without any accepted request");

    // a waiting result holds until popped
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(out_byte) && $stable(has_byte)
                              && $stable(end_of_string)))
        else $error("waiting result changed before pop");

endmodule

bind utf8_byte_sanitizer_top u8s_port_props u_u8s_port_props (.*);
`default_nettype wire
